FILE: hw/rtl/bilinear_upscale_alpha_defines.svh
// Assertion macros for the bilinear alpha upscaler checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef BILINEAR_UPSCALE_ALPHA_DEFINES_SVH
`define BILINEAR_UPSCALE_ALPHA_DEFINES_SVH

// General property, sampled on clk_i, off during reset.
`define BUA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A stalled request keeps the given signal unchanged into the next cycle.
`define BUA_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

FILE: hw/rtl/bua_pkg.sv
// Shared constants, types and sizing helpers of the bilinear alpha upscaler.
// No dependencies.
`default_nettype none

package bua_pkg;

  localparam int unsigned DEF_SCALE     = 4;
  localparam int unsigned DEF_SRC_W_MAX = 256;
  localparam int unsigned DEF_SRC_H_MAX = 128;

  localparam int unsigned CFG_W  = 9;
  localparam int unsigned COL_W  = 10;
  localparam int unsigned ROW_W  = 9;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned SIZE_W = 11;

  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned NUM_BANKS = 4;

  localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 9'd256;
  localparam logic [7:0]       SRC_HEIGHT_RST = 8'd128;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic              is_load;
    logic [1:0]        wr_bank;
    logic [PIX_W-1:0]  value;
    logic [FRAC_W-1:0] wx;
    logic [FRAC_W-1:0] wy;
    logic              xpar;
    logic              ypar;
    logic              xsame;
    logic              ysame;
  } cmd_t;

  // Source store is split in four banks by column and row parity.
  function automatic int unsigned bank_depth(int unsigned w, int unsigned h);
    return ((w + 1) >> 1) * ((h + 1) >> 1);
  endfunction

  function automatic int unsigned addr_w(int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bua_fifo.sv
// Small register FIFO, used as command queue and as output buffer.
// No dependencies.
`default_nettype none

module bua_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bua_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bua_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bua_front.sv
// Front end: takes requests, maps sample coordinates to neighbours and weights,
// drops out-of-store loads and builds bank commands. Depends on bua_pkg.
`default_nettype none

module bua_front #(
  parameter int unsigned Scale   = bua_pkg::DEF_SCALE,
  parameter int unsigned SrcWMax = bua_pkg::DEF_SRC_W_MAX,
  parameter int unsigned SrcHMax = bua_pkg::DEF_SRC_H_MAX,
  parameter int unsigned AddrW   = bua_pkg::addr_w(bua_pkg::bank_depth(SrcWMax, SrcHMax))
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [bua_pkg::CFG_W-1:0]         src_width_i,
  input  logic [7:0]                        src_height_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [bua_pkg::COL_W-1:0]         col_i,
  input  logic [bua_pkg::ROW_W-1:0]         row_i,
  input  logic [bua_pkg::PIX_W-1:0]         load_value_i,
  output logic                              push_o,
  output bua_pkg::cmd_t                     cmd_o,
  output logic [bua_pkg::NUM_BANKS-1:0][AddrW-1:0] addr_o,
  input  logic                              full_i
);

  localparam int unsigned NW     = bua_pkg::COL_W + bua_pkg::FRAC_W;
  localparam int unsigned KSh    = NW + 5;
  localparam int unsigned MW     = KSh + 1;
  localparam longint unsigned RecipL = ((64'd1 << KSh) + 64'(Scale) - 64'd1) / 64'(Scale);
  localparam logic [MW-1:0] Recip   = MW'(RecipL);
  localparam logic [NW-1:0] HalfPix = NW'(128);
  localparam int unsigned HalfW   = (SrcWMax + 1) / 2;
  localparam int unsigned SzW     = bua_pkg::SIZE_W;
  localparam int unsigned CW      = bua_pkg::COL_W;

  typedef struct packed {
    logic [CW-1:0]                 k0;
    logic [CW-1:0]                 k1;
    logic [bua_pkg::FRAC_W-1:0]    f;
  } place_t;

  // (2d+1)*128 as 10.1 coordinate shifted into an 8-bit fraction
  function automatic logic [NW-1:0] numer(logic [CW-1:0] d);
    return {d, 1'b1, 7'b0};
  endfunction

  function automatic place_t place(logic [NW-1:0] t, logic [SzW-1:0] size);
    logic [NW-1:0] p;
    place_t        r;
    p    = (t >= HalfPix) ? t - HalfPix : '0;
    r.k0 = p[NW-1:bua_pkg::FRAC_W];
    r.f  = p[bua_pkg::FRAC_W-1:0];
    if ({1'b0, r.k0} >= size) begin
      r.k0 = CW'(size - SzW'(1));
      r.f  = '0;
    end
    r.k1 = (({1'b0, r.k0} + SzW'(1)) < size) ? r.k0 + CW'(1) : r.k0;
    return r;
  endfunction

  logic [NW+MW-1:0] prod_x, prod_y;
  logic             accept;

  logic                       f1_v_q, f1_v_d;
  logic                       f1_mode_q;
  logic [CW-1:0]              f1_col_q;
  logic [bua_pkg::ROW_W-1:0]  f1_row_q;
  logic [bua_pkg::PIX_W-1:0]  f1_val_q;
  logic [NW-1:0]              f1_tx_q, f1_ty_q;

  logic [SzW-1:0]             sw, sh;
  place_t                     pl_x, pl_y;
  logic                       is_load, drop, done;
  logic [1:0][CW-1:0]         cx, cy;

  assign prod_x = (NW+MW)'(numer(col_i)) * (NW+MW)'(Recip);
  assign prod_y = (NW+MW)'(numer(CW'(row_i))) * (NW+MW)'(Recip);

  assign is_load = (f1_mode_q == bua_pkg::MODE_LOAD);
  assign drop    = is_load && ((32'(f1_col_q) >= SrcWMax) || (32'(f1_row_q) >= SrcHMax));
  assign done    = f1_v_q && (drop || !full_i);
  assign push_o  = f1_v_q && !drop && !full_i;

  assign in_ready_o = !f1_v_q || done;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (src_width_i == '0) begin
      sw = SzW'(1);
    end else if (32'(src_width_i) > SrcWMax) begin
      sw = SzW'(SrcWMax);
    end else begin
      sw = SzW'(src_width_i);
    end
    if (src_height_i == '0) begin
      sh = SzW'(1);
    end else if (32'(src_height_i) > SrcHMax) begin
      sh = SzW'(SrcHMax);
    end else begin
      sh = SzW'(src_height_i);
    end
  end

  assign pl_x = place(f1_tx_q, sw);
  assign pl_y = place(f1_ty_q, sh);

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      if (is_load) begin
        cx[b] = f1_col_q;
        cy[b] = CW'(f1_row_q);
      end else begin
        cx[b] = (pl_x.k0[0] == 1'(b)) ? pl_x.k0 : pl_x.k1;
        cy[b] = (pl_y.k0[0] == 1'(b)) ? pl_y.k0 : pl_y.k1;
      end
    end
    for (int i = 0; i < bua_pkg::NUM_BANKS; i++) begin
      addr_o[i] = AddrW'(32'(cy[i / 2][CW-1:1]) * HalfW + 32'(cx[i % 2][CW-1:1]));
    end
  end

  always_comb begin
    cmd_o.is_load = is_load;
    cmd_o.wr_bank = {f1_row_q[0], f1_col_q[0]};
    cmd_o.value   = f1_val_q;
    cmd_o.wx      = pl_x.f;
    cmd_o.wy      = pl_y.f;
    cmd_o.xpar    = pl_x.k0[0];
    cmd_o.ypar    = pl_y.k0[0];
    cmd_o.xsame   = (pl_x.k0 == pl_x.k1);
    cmd_o.ysame   = (pl_y.k0 == pl_y.k1);
  end

  always_comb begin
    f1_v_d = f1_v_q;
    if (accept) begin
      f1_v_d = 1'b1;
    end else if (done) begin
      f1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else begin
      f1_v_q <= f1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_mode_q <= mode_i;
      f1_col_q  <= col_i;
      f1_row_q  <= row_i;
      f1_val_q  <= load_value_i;
      f1_tx_q   <= prod_x[KSh +: NW];
      f1_ty_q   <= prod_y[KSh +: NW];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bua_back.sv
// Back end: banked source store, two-stage bilinear blend and output buffer.
// Depends on bua_pkg, bua_ram and bua_fifo.
`default_nettype none

module bua_back #(
  parameter int unsigned SrcWMax = bua_pkg::DEF_SRC_W_MAX,
  parameter int unsigned SrcHMax = bua_pkg::DEF_SRC_H_MAX,
  parameter int unsigned AddrW   = bua_pkg::addr_w(bua_pkg::bank_depth(SrcWMax, SrcHMax))
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cmd_valid_i,
  input  bua_pkg::cmd_t                            cmd_i,
  input  logic [bua_pkg::NUM_BANKS-1:0][AddrW-1:0] addr_i,
  output logic                                     cmd_pop_o,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [bua_pkg::PIX_W-1:0]                alpha_o
);

  localparam int unsigned BankDepth = bua_pkg::bank_depth(SrcWMax, SrcHMax);
  localparam int unsigned CrW       = $clog2(bua_pkg::OUT_DEPTH + 1);
  localparam int unsigned PW        = bua_pkg::PIX_W;
  localparam int unsigned FW        = bua_pkg::FRAC_W;
  localparam int unsigned AW        = PW + FW;

  logic [CrW-1:0] credit_q, credit_d;
  logic           pop_smp, out_fire, out_empty;

  logic [PW-1:0]  rd [bua_pkg::NUM_BANKS];

  logic           s1_v_q;
  logic [FW-1:0]  s1_wx_q, s1_wy_q;
  logic           s1_xpar_q, s1_ypar_q, s1_xsame_q, s1_ysame_q;
  logic           xo, yo;
  logic [PW-1:0]  p00, p10, p01, p11;
  logic [FW:0]    wxc, wyc;
  logic [AW-1:0]  a_d, b_d;

  logic           s2_v_q;
  logic [AW-1:0]  a_q, b_q;
  logic [FW-1:0]  s2_wy_q;
  logic [AW+FW:0] sum;

  assign cmd_pop_o = cmd_valid_i && (cmd_i.is_load || (credit_q != '0));
  assign pop_smp   = cmd_pop_o && !cmd_i.is_load;
  assign out_valid_o = !out_empty;
  assign out_fire  = out_valid_o && out_ready_i;

  for (genvar gi = 0; gi < bua_pkg::NUM_BANKS; gi++) begin : g_bank
    bua_ram #(
      .Width (PW),
      .Depth (BankDepth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_pop_o && cmd_i.is_load && (cmd_i.wr_bank == 2'(gi))),
      .waddr_i (addr_i[gi]),
      .wdata_i (cmd_i.value),
      .re_i    (pop_smp),
      .raddr_i (addr_i[gi]),
      .rdata_o (rd[gi])
    );
  end

  // edge-clamped neighbour reuses the near pixel
  assign xo  = s1_xpar_q ^ !s1_xsame_q;
  assign yo  = s1_ypar_q ^ !s1_ysame_q;
  assign p00 = rd[{s1_ypar_q, s1_xpar_q}];
  assign p10 = rd[{s1_ypar_q, xo}];
  assign p01 = rd[{yo, s1_xpar_q}];
  assign p11 = rd[{yo, xo}];

  assign wxc = (FW+1)'(256) - (FW+1)'(s1_wx_q);
  assign a_d = AW'((AW+1)'(p00) * (AW+1)'(wxc) + (AW+1)'(p10) * (AW+1)'(s1_wx_q));
  assign b_d = AW'((AW+1)'(p01) * (AW+1)'(wxc) + (AW+1)'(p11) * (AW+1)'(s1_wx_q));

  assign wyc = (FW+1)'(256) - (FW+1)'(s2_wy_q);
  assign sum = (AW+FW+1)'(a_q) * (AW+FW+1)'(wyc) + (AW+FW+1)'(b_q) * (AW+FW+1)'(s2_wy_q);

  bua_fifo #(
    .Width (PW),
    .Depth (bua_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_v_q),
    .wdata_i (sum[2*FW +: PW]),
    .full_o  (),
    .pop_i   (out_ready_i),
    .rdata_o (alpha_o),
    .empty_o (out_empty)
  );

  always_comb begin
    credit_d = credit_q;
    if (pop_smp && !out_fire) begin
      credit_d = credit_q - CrW'(1);
    end else if (out_fire && !pop_smp) begin
      credit_d = credit_q + CrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= CrW'(bua_pkg::OUT_DEPTH);
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
    end else begin
      credit_q <= credit_d;
      s1_v_q   <= pop_smp;
      s2_v_q   <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_smp) begin
      s1_wx_q    <= cmd_i.wx;
      s1_wy_q    <= cmd_i.wy;
      s1_xpar_q  <= cmd_i.xpar;
      s1_ypar_q  <= cmd_i.ypar;
      s1_xsame_q <= cmd_i.xsame;
      s1_ysame_q <= cmd_i.ysame;
    end
    if (s1_v_q) begin
      a_q     <= a_d;
      b_q     <= b_d;
      s2_wy_q <= s1_wy_q;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bilinear_upscale_alpha.sv
// Top level of the bilinear alpha upscaler: size registers, front end,
// command queue and back end. Depends on bua_pkg, bua_front, bua_fifo, bua_back.
`default_nettype none

// Takes one request per clock, load or sample, unless the queue is full, with
// results in request order. A load gives no result, and a load outside the
// store is dropped. The source store is four RAM banks split by column and row
// parity, so a sample's four neighbours come from one read port each, which
// sets the rate of one request per clock. The store has no clearing pass and is
// usable at once after reset; sampling a pixel never loaded gives an
// unspecified alpha. The user must write size registers only while no request
// is in flight; the block itself does not enforce this. A size of zero acts as
// one and one above the maximum as the maximum.
module bilinear_upscale_alpha #(
  parameter int unsigned SCALE     = bua_pkg::DEF_SCALE,
  parameter int unsigned SRC_W_MAX = bua_pkg::DEF_SRC_W_MAX,
  parameter int unsigned SRC_H_MAX = bua_pkg::DEF_SRC_H_MAX
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [bua_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic [bua_pkg::COL_W-1:0] col_i,
  input  logic [bua_pkg::ROW_W-1:0] row_i,
  input  logic [bua_pkg::PIX_W-1:0] load_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bua_pkg::PIX_W-1:0] alpha_o
);

  localparam int unsigned AddrW =
    bua_pkg::addr_w(bua_pkg::bank_depth(SRC_W_MAX, SRC_H_MAX));
  localparam int unsigned QW = $bits(bua_pkg::cmd_t) + bua_pkg::NUM_BANKS * AddrW;

  logic [bua_pkg::CFG_W-1:0] src_width_q;
  logic [7:0]                src_height_q;

  logic                                     f_push, q_full, q_empty, q_pop;
  bua_pkg::cmd_t                            f_cmd, b_cmd;
  logic [bua_pkg::NUM_BANKS-1:0][AddrW-1:0] f_addr, b_addr;
  logic [QW-1:0]                            q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= bua_pkg::SRC_WIDTH_RST;
      src_height_q <= bua_pkg::SRC_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (bua_pkg::reg_idx_e'(cfg_idx_i))
        bua_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_wdata_i;
        bua_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  bua_front #(
    .Scale   (SCALE),
    .SrcWMax (SRC_W_MAX),
    .SrcHMax (SRC_H_MAX),
    .AddrW   (AddrW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_width_i  (src_width_q),
    .src_height_i (src_height_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .load_value_i (load_value_i),
    .push_o       (f_push),
    .cmd_o        (f_cmd),
    .addr_o       (f_addr),
    .full_i       (q_full)
  );

  bua_fifo #(
    .Width (QW),
    .Depth (bua_pkg::Q_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i ({f_cmd, f_addr}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign {b_cmd, b_addr} = q_rdata;

  bua_back #(
    .SrcWMax (SRC_W_MAX),
    .SrcHMax (SRC_H_MAX),
    .AddrW   (AddrW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (b_cmd),
    .addr_i      (b_addr),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .alpha_o     (alpha_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/bua_checker.sv
// Port-level checker for the bilinear alpha upscaler, bound to the top level.
// Depends on bua_pkg and bilinear_upscale_alpha_defines.svh.
`default_nettype none
`include "bilinear_upscale_alpha_defines.svh"

module bua_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic                      out_valid_o,
  input  logic                      out_ready_i,
  input  logic [bua_pkg::PIX_W-1:0] alpha_o
);

  localparam int unsigned PendW = 5;

  logic [PendW-1:0] pend_q, pend_d;
  logic             smp_in, res_out;

  assign smp_in  = in_valid_i && in_ready_o && (mode_i == bua_pkg::MODE_SAMPLE);
  assign res_out = out_valid_o && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (smp_in && !res_out) begin
      pend_d = pend_q + PendW'(1);
    end else if (res_out && !smp_in) begin
      pend_d = pend_q - PendW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `BUA_ASSERT_HOLD(a_out_valid_hold, out_valid_o, out_ready_i, out_valid_o, "result request dropped while stalled")
  `BUA_ASSERT_HOLD(a_out_data_hold, out_valid_o, out_ready_i, alpha_o, "alpha changed while stalled")
  `BUA_ASSERT(a_no_spurious, (pend_q == '0) |-> !out_valid_o, "result without pending sample request")
  `BUA_ASSERT(a_load_silent, (pend_q == '0) && in_valid_i && in_ready_o && (mode_i == bua_pkg::MODE_LOAD) |=> !out_valid_o, "load request produced a result")

endmodule

bind bilinear_upscale_alpha bua_checker u_bua_checker (.*);

`default_nettype wire

FILE: tb/bilinear_upscale_alpha_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bilinear_upscale_alpha: a directed table, then random
// load/sample traffic over several size settings, checked against an in-bench predictor.
// Depends on bua_pkg and the bilinear_upscale_alpha RTL.

module bilinear_upscale_alpha_tb;

  localparam int unsigned SCALE     = bua_pkg::DEF_SCALE;
  localparam int unsigned W_MAX     = bua_pkg::DEF_SRC_W_MAX;
  localparam int unsigned H_MAX     = bua_pkg::DEF_SRC_H_MAX;
  localparam int unsigned CW        = bua_pkg::CFG_W;
  localparam int unsigned XW        = bua_pkg::COL_W;
  localparam int unsigned YW        = bua_pkg::ROW_W;
  localparam int unsigned PW        = bua_pkg::PIX_W;
  localparam int unsigned SETTLE    = 12;
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned WATCHDOG  = 1000;
  localparam int unsigned MAX_STEPS = 32;

  typedef struct packed {
    logic              is_cfg;
    bua_pkg::reg_idx_e sel;
    logic [CW-1:0]     cfg_val;
    logic              mode;
    logic [XW-1:0]     col;
    logic [YW-1:0]     row;
    logic [PW-1:0]     value;
    logic              typed;
    logic [PW-1:0]     alpha;
  } dir_step_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [0:0]    cfg_idx_i;
  logic [CW-1:0] cfg_wdata_i;
  logic          in_valid_i;
  logic          in_ready_o;
  logic          mode_i;
  logic [XW-1:0] col_i;
  logic [YW-1:0] row_i;
  logic [PW-1:0] load_value_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic [PW-1:0] alpha_o;

  // predictor state
  logic [PW-1:0] src_img  [0:W_MAX*H_MAX-1];
  bit            src_seen [0:W_MAX*H_MAX-1];
  logic [CW-1:0] width_reg;
  logic [7:0]    height_reg;
  logic [PW-1:0] alpha_due [$];

  dir_step_t   steps [0:MAX_STEPS-1];
  int unsigned n_steps;
  bit          in_burst;
  bit          long_hold;
  logic [PW-1:0] want;
  int unsigned idle_cycles;
  int unsigned n_loads, n_dropped, n_samples, n_items, n_checked, n_bad, n_cfg;

  bilinear_upscale_alpha uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .load_value_i (load_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .alpha_o      (alpha_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned eff_dim(input int unsigned v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // destination coordinate -> upper/lower neighbour and 8-bit weight
  function automatic void map_coord(input int unsigned d, input int unsigned size,
                                    output int unsigned lo, output int unsigned hi,
                                    output int unsigned frac);
    int unsigned t, p;
    t = ((2 * d + 1) * 256) / (2 * SCALE);
    p = (t >= 128) ? t - 128 : 0;
    lo = p >> 8;
    frac = p & 32'hFF;
    if (lo >= size) begin
      lo = size - 1;
      frac = 0;
    end
    hi = (lo + 1 < size) ? lo + 1 : lo;
  endfunction

  function automatic logic [PW-1:0] interp_alpha(input int unsigned c, input int unsigned r);
    int unsigned sw, sh, x0, x1, wx, y0, y1, wy, top, bot, acc;
    sw = eff_dim(width_reg, W_MAX);
    sh = eff_dim(height_reg, H_MAX);
    map_coord(c, sw, x0, x1, wx);
    map_coord(r, sh, y0, y1, wy);
    top = src_img[y0*W_MAX + x0] * (256 - wx) + src_img[y0*W_MAX + x1] * wx;
    bot = src_img[y1*W_MAX + x0] * (256 - wx) + src_img[y1*W_MAX + x1] * wx;
    acc = (top * (256 - wy) + bot * wy) >> 16;
    return acc[7:0];
  endfunction

  task automatic tab(input logic is_cfg, input bua_pkg::reg_idx_e sel,
                     input logic [CW-1:0] cv, input logic md, input logic [XW-1:0] c,
                     input logic [YW-1:0] r, input logic [PW-1:0] v, input logic typed,
                     input logic [PW-1:0] a);
    steps[n_steps] = '{is_cfg, sel, cv, md, c, r, v, typed, a};
    n_steps++;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input logic md, input logic [XW-1:0] c,
                          input logic [YW-1:0] r, input logic [PW-1:0] v,
                          input logic typed, input logic [PW-1:0] typed_alpha);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    gap = (in_burst || long_hold) ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i = md;
    col_i = c;
    row_i = r;
    load_value_i = v;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (md == bua_pkg::MODE_LOAD) begin
      if (c < W_MAX && r < H_MAX) begin
        src_img[r*W_MAX + c] = v;
        src_seen[r*W_MAX + c] = 1'b1;
        n_loads++;
        n_items++;
      end else begin
        n_dropped++;
      end
    end else begin
      alpha_due.push_back(typed ? typed_alpha : interp_alpha(c, r));
      n_samples++;
      n_items++;
    end
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (alpha_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input bua_pkg::reg_idx_e sel, input logic [CW-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = sel;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (sel == bua_pkg::REG_SRC_WIDTH) width_reg = data;
    else height_reg = data[7:0];
    n_cfg++;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : drive_out
    int unsigned stall;
    bit out_burst;
    out_burst = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      if (long_hold) begin
        out_ready_i = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold = 1'b0;
      end else begin
        stall = out_burst ? 0 : $urandom_range(0, 5);
        if (stall != 0) begin
          out_ready_i = 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      out_ready_i = 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (alpha_due.size() == 0) begin
        $display("%0t: unexpected alpha, expected none, got %0d", $time, alpha_o);
        n_bad++;
      end else begin
        want = alpha_due.pop_front();
        if (alpha_o !== want) begin
          $display("%0t: alpha mismatch, expected %0d, got %0d", $time, want, alpha_o);
          n_bad++;
        end
      end
      n_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG) begin
      $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG);
      $display("** bilinear_upscale_alpha: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned i, k, ph, stop_at, sw, sh, lim_c, lim_r, c, r, px, py;
    int unsigned x0, x1, wx, y0, y1, wy, pick;
    logic [CW-1:0] w, h;
    bit hold_done;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = bua_pkg::REG_SRC_WIDTH;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    mode_i = bua_pkg::MODE_LOAD;
    col_i = '0;
    row_i = '0;
    load_value_i = '0;
    in_burst = 1'b0;
    long_hold = 1'b0;
    hold_done = 1'b0;
    idle_cycles = 0;
    width_reg = bua_pkg::SRC_WIDTH_RST;
    height_reg = bua_pkg::SRC_HEIGHT_RST;
    for (i = 0; i < W_MAX*H_MAX; i++) begin
      src_img[i] = '0;
      src_seen[i] = 1'b0;
    end
    n_steps = 0;

    // sizes at reset values first
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_LOAD, 0, 0, 8'hFF, 0, 0);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_LOAD, 1, 0, 8'h00, 0, 0);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_LOAD, 0, 1, 8'h00, 0, 0);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_LOAD, 1, 1, 8'h00, 0, 0);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_SAMPLE, 0, 0, 8'h00, 1, 8'hFF);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_SAMPLE, 2, 0, 8'hFF, 0, 0);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_SAMPLE, 0, 2, 8'h00, 0, 0);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_LOAD, 255, 127, 8'hAB, 0, 0);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_SAMPLE, 1023, 511, 8'hFF, 1, 8'hAB);
    // loads outside the store must be dropped, not wrapped
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_LOAD, 256, 1, 8'h77, 0, 0);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_LOAD, 0, 128, 8'h77, 0, 0);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_LOAD, 1023, 511, 8'h77, 0, 0);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_SAMPLE, 0, 2, 8'h00, 0, 0);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_SAMPLE, 1023, 511, 8'h00, 1, 8'hAB);
    // single-pixel image, then zero sizes acting as one
    tab(1, bua_pkg::REG_SRC_WIDTH, 9'd1, bua_pkg::MODE_LOAD, 0, 0, 0, 0, 0);
    tab(1, bua_pkg::REG_SRC_HEIGHT, 9'd1, bua_pkg::MODE_LOAD, 0, 0, 0, 0, 0);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_SAMPLE, 0, 0, 8'h00, 1, 8'hFF);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_SAMPLE, 1023, 511, 8'h00, 1, 8'hFF);
    tab(1, bua_pkg::REG_SRC_WIDTH, 9'd0, bua_pkg::MODE_LOAD, 0, 0, 0, 0, 0);
    tab(1, bua_pkg::REG_SRC_HEIGHT, 9'd0, bua_pkg::MODE_LOAD, 0, 0, 0, 0, 0);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_SAMPLE, 517, 300, 8'h00, 1, 8'hFF);
    // oversize values clip to the store size
    tab(1, bua_pkg::REG_SRC_WIDTH, 9'h1FF, bua_pkg::MODE_LOAD, 0, 0, 0, 0, 0);
    tab(1, bua_pkg::REG_SRC_HEIGHT, 9'h1FF, bua_pkg::MODE_LOAD, 0, 0, 0, 0, 0);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_SAMPLE, 1023, 511, 8'h00, 1, 8'hAB);
    tab(0, bua_pkg::REG_SRC_WIDTH, 0, bua_pkg::MODE_SAMPLE, 1, 2, 8'h00, 0, 0);

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < n_steps; i++) begin
      if (steps[i].is_cfg) begin
        settle();
        write_reg(steps[i].sel, steps[i].cfg_val);
      end else begin
        send_req(steps[i].mode, steps[i].col, steps[i].row, steps[i].value,
                 steps[i].typed, steps[i].alpha);
      end
    end

    for (ph = 0; ph < 7; ph++) begin
      settle();
      case (ph)
        0: begin w = 256; h = 128; end
        1: begin w = 1; h = 1; end
        3: begin w = CW'($urandom_range(0, 511)); h = CW'($urandom_range(0, 511)); end
        4: begin w = CW'($urandom_range(1, 6)); h = CW'($urandom_range(1, 6)); end
        5: begin w = 0; h = 0; end
        default: begin
          w = CW'($urandom_range(2, 256));
          h = CW'($urandom_range(2, 128));
        end
      endcase
      write_reg(bua_pkg::REG_SRC_WIDTH, w);
      write_reg(bua_pkg::REG_SRC_HEIGHT, h);
      sw = eff_dim(width_reg, W_MAX);
      sh = eff_dim(height_reg, H_MAX);
      lim_c = (sw * SCALE + 3 > 1023) ? 1023 : sw * SCALE + 3;
      lim_r = (sh * SCALE + 3 > 511) ? 511 : sh * SCALE + 3;
      stop_at = n_items + 100;
      while (n_items < stop_at) begin
        if (ph == 2 && !hold_done && n_items + 70 >= stop_at) begin
          long_hold = 1'b1;
          hold_done = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          if ($urandom_range(0, 3) != 0) begin
            c = $urandom_range(0, lim_c);
            r = $urandom_range(0, lim_r);
          end else begin
            c = $urandom_range(0, 1023);
            r = $urandom_range(0, 511);
          end
          // load any neighbour not yet written before sampling
          map_coord(c, sw, x0, x1, wx);
          map_coord(r, sh, y0, y1, wy);
          for (k = 0; k < 4; k++) begin
            px = k[0] ? x1 : x0;
            py = k[1] ? y1 : y0;
            if (!src_seen[py*W_MAX + px])
              send_req(bua_pkg::MODE_LOAD, px[XW-1:0], py[YW-1:0],
                       PW'($urandom_range(0, 255)), 0, 0);
          end
          send_req(bua_pkg::MODE_SAMPLE, c[XW-1:0], r[YW-1:0],
                   PW'($urandom_range(0, 255)), 0, 0);
        end else if (pick < 90) begin
          c = $urandom_range(0, sw - 1);
          r = $urandom_range(0, sh - 1);
          send_req(bua_pkg::MODE_LOAD, c[XW-1:0], r[YW-1:0],
                   ($urandom_range(0, 7) == 0) ? 8'hFF : PW'($urandom_range(0, 255)), 0, 0);
        end else begin
          send_req(bua_pkg::MODE_LOAD, XW'($urandom_range(0, 1023)),
                   YW'($urandom_range(0, 511)), PW'($urandom_range(0, 255)), 0, 0);
        end
      end
    end

    settle();
    $display("Covered %0d stored loads, %0d dropped loads and %0d samples, %0d size writes.",
             n_loads, n_dropped, n_samples, n_cfg);
    $display("%0d alpha results checked, %0d mismatches.", n_checked, n_bad);
    if (n_bad == 0)
      $display("** bilinear_upscale_alpha: PASSED **");
    else
      $display("** bilinear_upscale_alpha: FAILED **");
    $finish;
  end

endmodule
